[rtl/gb3_pkg.sv]
// Shared types and constants for the 3x3 Gaussian blur RGB unit.
`default_nettype none

package gb3_pkg;

    // Fixed field widths.
    localparam int CHAN_BITS       = 8;
    localparam int NUM_CHAN        = 3;
    localparam int PIX_BITS        = NUM_CHAN * CHAN_BITS;
    localparam int WEIGHT_BITS     = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int ROW_BITS        = 13;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 16;

    // Geometry limits.
    localparam int KDIM        = 3;
    localparam int TAPS        = KDIM * KDIM;
    localparam int MIN_DIM     = 3;
    localparam int MAX_HEIGHT  = 4096;

    // Register map.
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT_CENTER = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT_EDGE   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT_CORNER = 3'd4;

    typedef logic [CHAN_BITS-1:0]   chan_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [PIX_BITS-1:0]    pixel_t;

    // Which neighbors of the output pixel lie inside the image.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } side_mask_t;

    // Stage load enables handed to every lane.
    typedef struct packed {
        logic load_sum;
        logic load_prod;
        logic load_acc;
    } lane_en_t;

endpackage

`default_nettype wire

[rtl/gaussian_blur_3x3_rgb_unit.sv]
// Top level of the 3x3 Gaussian blur for a raster stream of RGB pixels.
//
// Input beats (s_*) carry one pixel each in raster order, red in the low byte of
// s_tdata; s_tuser marks a flush beat. After a frame's last pixel the source sends
// image_width + 1 flush beats so that the last row of results drains out. Each output
// beat (m_*) is the filtered pixel, and m_tlast flags the frame's last result.
// Output pixel k belongs to the input beat accepted image_width + 1 beats after pixel k.
// The configuration channel (cfg_*) writes width, height and the three Q0.16 weights;
// it is always ready, and writing width or height restarts the frame. The user must make
// writes only while no beat is in flight; the block itself does not enforce this.
// Throughput is one beat per clock while the receiver keeps taking results. Once the
// beat that completes a result is accepted, the result passes the line buffer read,
// window shift, neighbor sums, weight products, then the total, shift and clamp.
// Three lanes, one per color, run side by side and the output stage merges them.
// Every stage advances whenever the stage after it is empty or moving, so a stalled
// receiver only holds up the input once all stages are full.
// Reset clears the counters, the stage valid bits and the registers to their defaults;
// the line buffers are not cleared, since rows not yet written in a frame only ever
// fall on neighbors outside the image, which are masked to zero.
`default_nettype none

module gaussian_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Configuration writes.
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [gb3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [gb3_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // Input pixels.
    input  wire logic                                 s_tvalid,
    output      logic                                 s_tready,
    input  wire logic [gb3_pkg::PIX_BITS-1:0]         s_tdata,  // red_in, green_in, blue_in
    input  wire logic [0:0]                           s_tuser,  // mode
    // Filtered pixels.
    output      logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    output      logic [gb3_pkg::PIX_BITS-1:0]         m_tdata,  // red_out, green_out, blue_out
    output      logic                                 m_tlast   // frame_end
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS = gb3_pkg::ROW_BITS;
    localparam int PIX_BITS = gb3_pkg::PIX_BITS;
    localparam int CMP_BITS = 13;
    localparam logic [CMP_BITS-1:0] MAX_WIDTH_EXT = CMP_BITS'(MAX_WIDTH);

    // Configuration registers.
    logic [gb3_pkg::WIDTH_REG_BITS-1:0]  image_width_reg;
    logic [gb3_pkg::HEIGHT_REG_BITS-1:0] image_height_reg;
    gb3_pkg::weight_t                    weight_center_reg;
    gb3_pkg::weight_t                    weight_edge_reg;
    gb3_pkg::weight_t                    weight_corner_reg;
    logic                                cfg_fire;
    logic                                restart;

    // Geometry and position counters.
    logic [CMP_BITS-1:0]  width_ext;
    logic [WID_BITS-1:0]  width_eff;
    logic [ROW_BITS-1:0]  height_eff;
    logic [COL_BITS-1:0]  in_col_reg;
    logic [ROW_BITS-1:0]  in_row_reg;
    logic [COL_BITS-1:0]  out_col_reg;
    logic [ROW_BITS-1:0]  out_row_reg;
    logic [WID_BITS-1:0]  in_col_inc;
    logic [WID_BITS-1:0]  out_col_inc;
    logic [ROW_BITS-1:0]  in_row_inc;
    logic [ROW_BITS-1:0]  out_row_inc;
    logic                 emit;
    logic                 frame_last;
    gb3_pkg::side_mask_t  mask;
    gb3_pkg::pixel_t      pix;
    logic                 s_fire;

    // Stage enables.
    logic en1, en2, en3, en4, en5, en_out;

    // Stage 1: line buffer read in flight.
    logic                 v1_reg;
    gb3_pkg::pixel_t      pix1_reg;
    logic [COL_BITS-1:0]  col1_reg;
    logic                 emit1_reg;
    logic                 last1_reg;
    gb3_pkg::side_mask_t  mask1_reg;
    logic [2*PIX_BITS-1:0] line_rd;
    gb3_pkg::pixel_t      older_rd;
    gb3_pkg::pixel_t      newer_rd;

    // Stage 2: the 3x3 window.
    logic                                   v2_reg;
    gb3_pkg::pixel_t [gb3_pkg::TAPS-1:0]    window_reg;
    logic                                   emit2_reg;
    logic                                   last2_reg;
    gb3_pkg::side_mask_t                    mask2_reg;

    // Stages 3 to 5 live in the lanes; only valid and frame flag travel here.
    logic v3_reg, v4_reg, v5_reg;
    logic last3_reg, last4_reg, last5_reg;

    gb3_pkg::lane_en_t                                          lane_en;
    gb3_pkg::chan_t [gb3_pkg::NUM_CHAN-1:0][gb3_pkg::TAPS-1:0]  lane_win;
    gb3_pkg::chan_t [gb3_pkg::NUM_CHAN-1:0]                     lane_result;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign restart   = cfg_fire && (cfg_index == gb3_pkg::REG_IMAGE_WIDTH ||
                                    cfg_index == gb3_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= 11'd128;
            image_height_reg  <= 13'd128;
            weight_center_reg <= 16'd10589;
            weight_edge_reg   <= 16'd7877;
            weight_corner_reg <= 16'd5860;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                gb3_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= cfg_data[gb3_pkg::WIDTH_REG_BITS-1:0];
                gb3_pkg::REG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[gb3_pkg::HEIGHT_REG_BITS-1:0];
                gb3_pkg::REG_WEIGHT_CENTER: weight_center_reg <= cfg_data;
                gb3_pkg::REG_WEIGHT_EDGE:   weight_edge_reg   <= cfg_data;
                gb3_pkg::REG_WEIGHT_CORNER: weight_corner_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Width and height as used: clamped to the supported range.
    always_comb begin
        width_ext = CMP_BITS'(image_width_reg);
        if (width_ext < CMP_BITS'(gb3_pkg::MIN_DIM)) begin
            width_eff = WID_BITS'(gb3_pkg::MIN_DIM);
        end else if (width_ext > MAX_WIDTH_EXT) begin
            width_eff = WID_BITS'(MAX_WIDTH);
        end else begin
            width_eff = width_ext[WID_BITS-1:0];
        end

        if (image_height_reg < ROW_BITS'(gb3_pkg::MIN_DIM)) begin
            height_eff = ROW_BITS'(gb3_pkg::MIN_DIM);
        end else if (image_height_reg > ROW_BITS'(gb3_pkg::MAX_HEIGHT)) begin
            height_eff = ROW_BITS'(gb3_pkg::MAX_HEIGHT);
        end else begin
            height_eff = image_height_reg;
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: positions, border masks and the incoming pixel.
    // ------------------------------------------------------------------
    assign s_fire = s_tvalid && s_tready;

    always_comb begin
        in_col_inc  = WID_BITS'(in_col_reg) + WID_BITS'(1);
        out_col_inc = WID_BITS'(out_col_reg) + WID_BITS'(1);
        in_row_inc  = in_row_reg + ROW_BITS'(1);
        out_row_inc = out_row_reg + ROW_BITS'(1);

        // The first result appears once the window is centered on pixel (0, 0),
        // which is the beat for row 1, column 1.
        emit = (in_row_reg >= ROW_BITS'(2)) ||
               (in_row_reg == ROW_BITS'(1) && in_col_reg != '0);

        mask.top    = (out_row_reg != '0);
        mask.bottom = (out_row_inc < height_eff);
        mask.left   = (out_col_reg != '0);
        mask.right  = (out_col_inc < width_eff);
        frame_last  = !mask.bottom && !mask.right;

        // Flush beats and beats past the last image row feed black pixels.
        if (!s_tuser[0] && in_row_reg < height_eff) begin
            pix = s_tdata;
        end else begin
            pix = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (s_fire) begin
            if (emit && frame_last) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                if (in_col_inc >= width_eff) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_inc;
                end else begin
                    in_col_reg <= in_col_inc[COL_BITS-1:0];
                end
                if (emit) begin
                    if (out_col_inc >= width_eff) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_inc;
                    end else begin
                        out_col_reg <= out_col_inc[COL_BITS-1:0];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its successor moves.
    // ------------------------------------------------------------------
    assign en5      = !v5_reg || en_out;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // ------------------------------------------------------------------
    // Stage 1: line buffers. Each entry holds {row R-2, row R-1} for a column.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pix1_reg  <= pix;
            col1_reg  <= in_col_reg;
            emit1_reg <= emit;
            last1_reg <= frame_last;
            mask1_reg <= mask;
        end
    end

    gb3_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2 * PIX_BITS)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (in_col_reg),
        .rd_data (line_rd),
        .wr_en   (v1_reg && en2),
        .wr_addr (col1_reg),
        .wr_data ({newer_rd, pix1_reg})
    );

    assign older_rd = line_rd[2*PIX_BITS-1:PIX_BITS];
    assign newer_rd = line_rd[PIX_BITS-1:0];

    // ------------------------------------------------------------------
    // Stage 2: shift the window left and bring in the new column.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            for (int r = 0; r < gb3_pkg::KDIM; r++) begin
                window_reg[r*gb3_pkg::KDIM + 0] <= window_reg[r*gb3_pkg::KDIM + 1];
                window_reg[r*gb3_pkg::KDIM + 1] <= window_reg[r*gb3_pkg::KDIM + 2];
            end
            window_reg[0*gb3_pkg::KDIM + 2] <= older_rd;
            window_reg[1*gb3_pkg::KDIM + 2] <= newer_rd;
            window_reg[2*gb3_pkg::KDIM + 2] <= pix1_reg;
            emit2_reg <= emit1_reg;
            last2_reg <= last1_reg;
            mask2_reg <= mask1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 to 5: per-channel lanes. Beats that give no result drop out here.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en3) v3_reg <= v2_reg && emit2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) last3_reg <= last2_reg;
        if (en4) last4_reg <= last3_reg;
        if (en5) last5_reg <= last4_reg;
    end

    assign lane_en.load_sum  = en3;
    assign lane_en.load_prod = en4;
    assign lane_en.load_acc  = en5;

    always_comb begin
        for (int ch = 0; ch < gb3_pkg::NUM_CHAN; ch++) begin
            for (int k = 0; k < gb3_pkg::TAPS; k++) begin
                lane_win[ch][k] = window_reg[k][ch*gb3_pkg::CHAN_BITS +: gb3_pkg::CHAN_BITS];
            end
        end
    end

    for (genvar ch = 0; ch < gb3_pkg::NUM_CHAN; ch++) begin : g_lane
        gb3_lane u_lane (
            .aclk          (aclk),
            .en            (lane_en),
            .win           (lane_win[ch]),
            .mask          (mask2_reg),
            .weight_center (weight_center_reg),
            .weight_edge   (weight_edge_reg),
            .weight_corner (weight_corner_reg),
            .result        (lane_result[ch])
        );
    end

    // ------------------------------------------------------------------
    // Output register: merges the lanes into one beat.
    // ------------------------------------------------------------------
    gb3_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v5_reg),
        .in_last     (last5_reg),
        .lane_result (lane_result),
        .load_ok     (en_out),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/gb3_line_buf.sv]
// Dual line buffer memory: one write port, one read port with registered data.
`default_nettype none

module gb3_line_buf #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 48
) (
    input  wire logic                         aclk,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    output      logic [DATA_BITS-1:0]         rd_data,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire logic [DATA_BITS-1:0]         wr_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/gb3_lane.sv]
// One color channel lane: masked neighbor sums, weight products, total and saturation.
`default_nettype none

module gb3_lane (
    input  wire logic                            aclk,
    input  wire gb3_pkg::lane_en_t               en,
    input  wire gb3_pkg::chan_t [8:0]            win,
    input  wire gb3_pkg::side_mask_t             mask,
    input  wire gb3_pkg::weight_t                weight_center,
    input  wire gb3_pkg::weight_t                weight_edge,
    input  wire gb3_pkg::weight_t                weight_corner,
    output      gb3_pkg::chan_t                  result
);

    localparam int SUM_BITS  = gb3_pkg::CHAN_BITS + 2;
    localparam int PC_BITS   = gb3_pkg::CHAN_BITS + gb3_pkg::WEIGHT_BITS;
    localparam int PS_BITS   = SUM_BITS + gb3_pkg::WEIGHT_BITS;
    localparam int ACC_BITS  = PS_BITS + 2;

    gb3_pkg::chan_t        center_reg;
    logic [SUM_BITS-1:0]   side_sum_next;
    logic [SUM_BITS-1:0]   side_sum_reg;
    logic [SUM_BITS-1:0]   corner_sum_next;
    logic [SUM_BITS-1:0]   corner_sum_reg;
    logic [PC_BITS-1:0]    prod_center_reg;
    logic [PS_BITS-1:0]    prod_side_reg;
    logic [PS_BITS-1:0]    prod_corner_reg;
    logic [ACC_BITS-1:0]   total;
    logic [ACC_BITS-1:0]   scaled;
    gb3_pkg::chan_t        result_next;
    gb3_pkg::chan_t        result_reg;

    // Taps are numbered row by row, top-left first.
    always_comb begin
        side_sum_next   = '0;
        corner_sum_next = '0;
        if (mask.top)                side_sum_next   = side_sum_next + SUM_BITS'(win[1]);
        if (mask.left)               side_sum_next   = side_sum_next + SUM_BITS'(win[3]);
        if (mask.right)              side_sum_next   = side_sum_next + SUM_BITS'(win[5]);
        if (mask.bottom)             side_sum_next   = side_sum_next + SUM_BITS'(win[7]);
        if (mask.top && mask.left)     corner_sum_next = corner_sum_next + SUM_BITS'(win[0]);
        if (mask.top && mask.right)    corner_sum_next = corner_sum_next + SUM_BITS'(win[2]);
        if (mask.bottom && mask.left)  corner_sum_next = corner_sum_next + SUM_BITS'(win[6]);
        if (mask.bottom && mask.right) corner_sum_next = corner_sum_next + SUM_BITS'(win[8]);
    end

    always_ff @(posedge aclk) begin
        if (en.load_sum) begin
            center_reg     <= win[4];
            side_sum_reg   <= side_sum_next;
            corner_sum_reg <= corner_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.load_prod) begin
            prod_center_reg <= PC_BITS'(center_reg) * PC_BITS'(weight_center);
            prod_side_reg   <= PS_BITS'(side_sum_reg) * PS_BITS'(weight_edge);
            prod_corner_reg <= PS_BITS'(corner_sum_reg) * PS_BITS'(weight_corner);
        end
    end

    // Truncate the fraction, then clamp at full scale.
    always_comb begin
        total  = ACC_BITS'(prod_center_reg) + ACC_BITS'(prod_side_reg)
               + ACC_BITS'(prod_corner_reg);
        scaled = total >> gb3_pkg::WEIGHT_FRAC_BITS;
        if (|scaled[ACC_BITS-1:gb3_pkg::CHAN_BITS]) begin
            result_next = '1;
        end else begin
            result_next = scaled[gb3_pkg::CHAN_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.load_acc) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/gb3_merge.sv]
// Output stage: joins the three lane results and the frame flag into one held beat.
`default_nettype none

module gb3_merge (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    input  wire logic                                  in_last,
    input  wire gb3_pkg::chan_t [gb3_pkg::NUM_CHAN-1:0] lane_result,
    output      logic                                  load_ok,
    output      logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    output      logic [gb3_pkg::PIX_BITS-1:0]          m_tdata,
    output      logic                                  m_tlast
);

    logic                          m_valid_reg;
    logic [gb3_pkg::PIX_BITS-1:0]  m_data_reg;
    logic                          m_last_reg;

    assign load_ok = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_ok) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ok && in_valid) begin
            m_data_reg <= lane_result;
            m_last_reg <= in_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

[rtl/gb3_checker.sv]
// Port-level checks for the Gaussian blur unit, bound to the top level.
`default_nettype none

module gb3_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          cfg_ready,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [gb3_pkg::PIX_BITS-1:0]  m_tdata,
    input wire logic                          m_tlast
);

    // A stalled result beat keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // With the output register free or draining, the whole pipeline moves.
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled although the output side was free");

    // No result comes out right after reset.
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_tvalid)
        else $error("output beat right after reset");

    // Register writes are never held off.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind gaussian_blur_3x3_rgb_unit gb3_checker u_gb3_checker (.*);

`default_nettype wire
